@@ hdl/shra_pkg.sv @@
// shared types and constants for the snr history rate adapter
`default_nettype none
package shra_pkg;

  localparam int CFG_IW = 2;

  localparam logic [CFG_IW-1:0] CFG_SNR_POOR = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_SNR_LOW  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_SNR_MID  = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_FAIL_LIM = 2'd3;

  localparam logic signed [9:0] SNR_POOR_RST = 10'sd40;
  localparam logic signed [9:0] SNR_LOW_RST  = 10'sd60;
  localparam logic signed [9:0] SNR_MID_RST  = 10'sd100;
  localparam logic [2:0]        FAIL_LIM_RST = 3'd4;

  typedef enum logic {
    OP_SUCCESS = 1'b0,
    OP_FAILURE = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [9:0] snr_poor;
    logic signed [9:0] snr_low;
    logic signed [9:0] snr_mid;
    logic [2:0]        fail_lim;
  } cfg_t;

  typedef struct packed {
    op_t               op;
    logic [5:0]        station;
    logic [5:0]        slot;
    logic signed [9:0] snr;
    logic [3:0]        maxr;
  } item_t;

endpackage
`default_nettype wire

@@ hdl/shra_front.sv @@
// front end: accepts event words, maps the station to a table slot and clamps the maximum rate
`default_nettype none
module shra_front #(
  parameter int STATIONS  = 64,
  parameter int MAX_RATES = 16
) (
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_opcode,
  input  wire logic [5:0]         in_station_index,
  input  wire logic signed [9:0]  in_snr_qdb,
  input  wire logic [3:0]         in_max_rate_index,
  input  wire logic               enable,
  input  wire logic               q_ready,
  output logic                    q_push,
  output shra_pkg::item_t         q_item
);
  import shra_pkg::*;

  localparam int MAXC = MAX_RATES - 1;
  localparam int RMW  = 18;

  logic [RMW-1:0] rem;
  logic [6:0]     maxr_x;

  assign in_ready = enable && q_ready;
  assign q_push   = in_valid && in_ready;

  // station modulo table size, one conditional subtract per quotient bit
  always_comb begin
    rem = RMW'(in_station_index);
    for (int k = 5; k >= 0; k--) begin
      if (rem >= (RMW'(STATIONS) << k)) begin
        rem = rem - (RMW'(STATIONS) << k);
      end
    end
  end

  assign maxr_x = {3'b000, in_max_rate_index};

  always_comb begin
    q_item.op      = op_t'(in_opcode);
    q_item.station = in_station_index;
    q_item.slot    = rem[5:0];
    q_item.snr     = in_snr_qdb;
    q_item.maxr    = (maxr_x > 7'(MAXC)) ? 4'(MAXC) : in_max_rate_index;
  end

endmodule
`default_nettype wire

@@ hdl/shra_queue.sv @@
// two entry queue between front end and table update
`default_nettype none
module shra_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire shra_pkg::item_t push_item,
  output logic                 push_ready,
  input  wire logic            pop,
  output logic                 pop_valid,
  output shra_pkg::item_t      pop_item
);
  import shra_pkg::*;

  item_t      slot_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

@@ hdl/shra_back.sv @@
// back end: station table, clearing pass, rate decision and result register
`default_nettype none
module shra_back #(
  parameter int STATIONS      = 64,
  parameter int HISTORY_DEPTH = 5,
  parameter int MAX_RATES     = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire shra_pkg::cfg_t  cfg,
  input  wire logic            q_valid,
  input  wire shra_pkg::item_t q_item,
  output logic                 q_pop,
  output logic                 clr_done,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [5:0]           out_station_out,
  output logic [3:0]           out_rate_index,
  output logic [2:0]           out_recent_failures
);
  import shra_pkg::*;

  localparam int HD = HISTORY_DEPTH;
  localparam int SW = (STATIONS > 1) ? $clog2(STATIONS) : 1;
  localparam int AW = (SW > 6) ? SW : 6;
  localparam int RW = $clog2(MAX_RATES);
  localparam int XW = ((RW > 4) ? RW : 4) + 1;
  localparam int PW = (HD > 1) ? $clog2(HD) : 1;
  localparam int FW = $clog2(HD + 1);
  localparam int CW = ((FW > 3) ? FW : 3) + 1;
  localparam int EW = RW + HD + PW + 1;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  localparam logic [EW-1:0] ENTRY_RST = {RW'(0), {HD{1'b1}}, PW'(0), 1'b0};

  logic [EW-1:0] mem [STATIONS];
  logic [EW-1:0] rd_data_r;

  state_t        state_r;
  state_t        state_nxt;
  logic [SW-1:0] clr_idx_r;
  logic [SW-1:0] clr_idx_nxt;
  item_t         work_r;
  logic [SW-1:0] work_idx;
  logic [SW-1:0] q_idx;
  logic [AW-1:0] work_slot_x;
  logic [AW-1:0] q_slot_x;

  logic          go;
  logic          mem_we;
  logic [SW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;

  logic          par;
  logic [PW-1:0] pos;
  logic [HD-1:0] ring;
  logic [RW-1:0] rate;
  logic [PW-1:0] pos_c;
  logic [PW:0]   pos_inc;
  logic [PW-1:0] pos_n;
  logic [HD-1:0] ring_n;
  logic          par_n;
  logic [CW-1:0] fails;
  logic [XW-1:0] rate_x;
  logic [XW-1:0] maxr_x;
  logic [XW-1:0] rate_n;
  logic [XW-1:0] rate_dn;
  logic [XW-1:0] rate_up;

  logic          out_valid_r;
  logic          out_valid_nxt;
  logic [5:0]    out_station_r;
  logic [3:0]    out_rate_r;
  logic [2:0]    out_fail_r;

  assign q_slot_x    = AW'(q_item.slot);
  assign q_idx       = q_slot_x[SW-1:0];
  assign work_slot_x = AW'(work_r.slot);
  assign work_idx    = work_slot_x[SW-1:0];

  assign clr_done = (state_r != ST_CLEAR);
  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign go       = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  // entry fields
  assign par  = rd_data_r[0];
  assign pos  = rd_data_r[PW:1];
  assign ring = rd_data_r[PW+HD:PW+1];
  assign rate = rd_data_r[EW-1:PW+HD+1];

  always_comb begin
    pos_c = ({1'b0, pos} >= (PW+1)'(HD)) ? PW'(0) : pos;
    for (int i = 0; i < HD; i++) begin
      ring_n[i] = (pos_c == PW'(i)) ? (work_r.op == OP_SUCCESS) : ring[i];
    end
    pos_inc = {1'b0, pos_c} + (PW+1)'(1);
    pos_n   = (pos_inc == (PW+1)'(HD)) ? PW'(0) : pos_inc[PW-1:0];
    fails   = CW'($countones(~ring_n));
  end

  always_comb begin
    rate_x  = XW'(rate);
    maxr_x  = XW'(work_r.maxr);
    rate_dn = (rate_x == XW'(0)) ? XW'(0) : rate_x - XW'(1);
    rate_up = ((rate_x + XW'(1)) < maxr_x) ? rate_x + XW'(1) : maxr_x;
    par_n   = 1'b0;
    if (work_r.op == OP_SUCCESS) begin
      if ((work_r.snr < cfg.snr_poor) || (fails >= CW'(cfg.fail_lim))) begin
        rate_n = rate_dn;
      end else if (work_r.snr < cfg.snr_low) begin
        rate_n = (maxr_x < XW'(1)) ? maxr_x : XW'(1);
      end else if (work_r.snr < cfg.snr_mid) begin
        rate_n = (maxr_x < XW'(2)) ? maxr_x : XW'(2);
      end else if (fails == CW'(0)) begin
        rate_n = maxr_x;
      end else begin
        rate_n = rate_up;
      end
    end else begin
      par_n  = ~par;
      rate_n = par ? rate_dn : rate_x;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_wa        = work_idx;
    mem_wd        = {rate_n[RW-1:0], ring_n, pos_n, par_n};
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_wa      = clr_idx_r;
        mem_wd      = ENTRY_RST;
        clr_idx_nxt = clr_idx_r + SW'(1);
        if (clr_idx_r == SW'(STATIONS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (go) begin
          mem_we        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= SW'(0);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      work_r <= q_item;
    end
    if (go) begin
      out_station_r <= work_r.station;
      out_rate_r    <= rate_n[3:0];
      out_fail_r    <= (fails > CW'(7)) ? 3'd7 : fails[2:0];
    end
  end

  // station table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (q_pop) begin
      rd_data_r <= mem[q_idx];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_station_out     = out_station_r;
  assign out_rate_index      = out_rate_r;
  assign out_recent_failures = out_fail_r;

endmodule
`default_nettype wire

@@ hdl/snr_history_rate_adapter_core.sv @@
// top level of the snr history rate adapter: config registers, front end, queue, back end
//
// channel  direction  ports                                   word
// in       input      in_valid/in_ready                       opcode, station, snr, max rate
// out      output     out_valid/out_ready                     station, rate index, failures
// cfg      input      cfg_valid/cfg_ready                     register index, write data
//
// each event passes the back end in steps: a registered table read, then the
// update, written back into the table and the result register; a new event is
// only popped once the last one is written. After reset the table is cleared
// one station per cycle, all STATIONS entries, with in_ready low; config writes are taken at any time
// a result waiting in the output register stalls the back end only when the
// next result is ready; the front end keeps filling the two entry queue until it is full
`default_nettype none
module snr_history_rate_adapter_core #(
  parameter int STATIONS      = 64,
  parameter int HISTORY_DEPTH = 5,
  parameter int MAX_RATES     = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_opcode,
  input  wire logic [5:0]                    in_station_index,
  input  wire logic signed [9:0]             in_snr_qdb,
  input  wire logic [3:0]                    in_max_rate_index,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [5:0]                         out_station_out,
  output logic [3:0]                         out_rate_index,
  output logic [2:0]                         out_recent_failures,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [shra_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [9:0]                    cfg_data
);
  import shra_pkg::*;

  cfg_t  cfg_r;
  cfg_t  cfg_nxt;
  logic  clr_done;
  logic  q_push;
  logic  q_push_ready;
  item_t q_in_item;
  logic  q_pop;
  logic  q_valid;
  item_t q_item;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SNR_POOR: cfg_nxt.snr_poor = cfg_data;
        CFG_SNR_LOW:  cfg_nxt.snr_low  = cfg_data;
        CFG_SNR_MID:  cfg_nxt.snr_mid  = cfg_data;
        CFG_FAIL_LIM: cfg_nxt.fail_lim = cfg_data[2:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.snr_poor <= SNR_POOR_RST;
      cfg_r.snr_low  <= SNR_LOW_RST;
      cfg_r.snr_mid  <= SNR_MID_RST;
      cfg_r.fail_lim <= FAIL_LIM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  shra_front #(
    .STATIONS  (STATIONS),
    .MAX_RATES (MAX_RATES)
  ) u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_station_index  (in_station_index),
    .in_snr_qdb        (in_snr_qdb),
    .in_max_rate_index (in_max_rate_index),
    .enable            (clr_done),
    .q_ready           (q_push_ready),
    .q_push            (q_push),
    .q_item            (q_in_item)
  );

  shra_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_in_item),
    .push_ready (q_push_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_item   (q_item)
  );

  shra_back #(
    .STATIONS      (STATIONS),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MAX_RATES     (MAX_RATES)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop),
    .clr_done            (clr_done),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_station_out     (out_station_out),
    .out_rate_index      (out_rate_index),
    .out_recent_failures (out_recent_failures)
  );

endmodule
`default_nettype wire

@@ hdl/shra_chk.sv @@
// port level checks for the snr history rate adapter, bound to the top level
`default_nettype none
module shra_chk #(
  parameter int HISTORY_DEPTH = 5
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [5:0]                  out_station_out,
  input wire logic [3:0]                  out_rate_index,
  input wire logic [2:0]                  out_recent_failures
);

  localparam int FAIL_MAX = (HISTORY_DEPTH > 7) ? 7 : HISTORY_DEPTH;

  // result word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_station_out)
      && $stable(out_rate_index) && $stable(out_recent_failures))
    else $error("result word changed while stalled");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // table clearing keeps the input closed right after reset
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open during table clearing");

  a_fail_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_recent_failures <= 3'(FAIL_MAX))
    else $error("failure count beyond history depth");

endmodule

bind snr_history_rate_adapter_core shra_chk #(
  .HISTORY_DEPTH (HISTORY_DEPTH)
) u_shra_chk (.*);
`default_nettype wire

@@ tb/sv/tb_snr_history_rate_adapter_core.sv @@
// self-checking testbench for snr_history_rate_adapter_core with a per-station rate predictor
module tb_snr_history_rate_adapter_core;
  import shra_pkg::*;

  localparam int STATIONS      = 64;
  localparam int HISTORY_DEPTH = 5;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [5:0] station;
    logic [3:0] rate;
    logic [2:0] fails;
  } rate_update_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_opcode = 1'b0;
  logic [5:0]              in_station_index = '0;
  logic signed [9:0]       in_snr_qdb = '0;
  logic [3:0]              in_max_rate_index = '0;
  logic                    out_ready = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [CFG_IW-1:0]       cfg_index = CFG_SNR_POOR;
  logic [9:0]              cfg_data = '0;
  wire                     in_ready;
  wire                     out_valid;
  wire  [5:0]              out_station_out;
  wire  [3:0]              out_rate_index;
  wire  [2:0]              out_recent_failures;
  wire                     cfg_ready;

  // predictor state
  cfg_t                    cur_cfg;
  logic [3:0]              rate_tbl [STATIONS];
  logic [HISTORY_DEPTH-1:0] ring_tbl [STATIONS];
  int                      pos_tbl [STATIONS];
  logic                    parity_tbl [STATIONS];
  rate_update_t            expected_updates [$];

  int burst_left = 0;
  int events_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int settings_used = 1;
  int ready_mode = 0;
  int ready_phase = 0;
  int stall_left = 0;
  rate_update_t want_update;
  rate_update_t got_update;

  snr_history_rate_adapter_core uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_station_index    (in_station_index),
    .in_snr_qdb          (in_snr_qdb),
    .in_max_rate_index   (in_max_rate_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_station_out     (out_station_out),
    .out_rate_index      (out_rate_index),
    .out_recent_failures (out_recent_failures),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic clear_station_table();
    int s;
    cur_cfg.snr_poor = SNR_POOR_RST;
    cur_cfg.snr_low  = SNR_LOW_RST;
    cur_cfg.snr_mid  = SNR_MID_RST;
    cur_cfg.fail_lim = FAIL_LIM_RST;
    for (s = 0; s < STATIONS; s++) begin
      rate_tbl[s]   = '0;
      ring_tbl[s]   = '1;
      pos_tbl[s]    = 0;
      parity_tbl[s] = 1'b0;
    end
  endtask

  function automatic rate_update_t predict_rate_update(op_t op, logic [5:0] st_in,
                                                       logic signed [9:0] snr,
                                                       logic [3:0] maxr);
    int s, pos, rate, fails, snr_v, mx, i;
    rate_update_t r;
    s     = st_in % STATIONS;
    pos   = pos_tbl[s];
    rate  = rate_tbl[s];
    snr_v = snr;
    mx    = maxr;
    if (pos >= HISTORY_DEPTH) pos = 0;
    ring_tbl[s][pos] = (op == OP_SUCCESS);
    pos_tbl[s] = (pos + 1) % HISTORY_DEPTH;
    fails = 0;
    for (i = 0; i < HISTORY_DEPTH; i++)
      if (!ring_tbl[s][i]) fails++;
    if (op == OP_SUCCESS) begin
      parity_tbl[s] = 1'b0;
      if (snr_v < int'($signed(cur_cfg.snr_poor)) || fails >= int'(cur_cfg.fail_lim))
        rate = (rate > 0) ? rate - 1 : 0;
      else if (snr_v < int'($signed(cur_cfg.snr_low)))
        rate = (mx < 1) ? mx : 1;
      else if (snr_v < int'($signed(cur_cfg.snr_mid)))
        rate = (mx < 2) ? mx : 2;
      else if (fails == 0)
        rate = mx;
      else
        rate = (rate + 1 < mx) ? rate + 1 : mx;
    end else begin
      parity_tbl[s] = ~parity_tbl[s];
      if (!parity_tbl[s] && rate != 0) rate = rate - 1;
    end
    rate_tbl[s] = rate[3:0];
    r.station = st_in;
    r.rate    = rate[3:0];
    r.fails   = (fails > 7) ? 3'd7 : fails[2:0];
    return r;
  endfunction

  task automatic send_event(op_t op, logic [5:0] st, logic signed [9:0] snr,
                            logic [3:0] maxr);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    in_valid          <= 1'b1;
    in_opcode         <= op;
    in_station_index  <= st;
    in_snr_qdb        <= snr;
    in_max_rate_index <= maxr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_updates.push_back(predict_rate_update(op, st, snr, maxr));
    events_sent++;
    burst_left--;
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [9:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SNR_POOR: cur_cfg.snr_poor = data;
      CFG_SNR_LOW:  cur_cfg.snr_low  = data;
      CFG_SNR_MID:  cur_cfg.snr_mid  = data;
      CFG_FAIL_LIM: cur_cfg.fail_lim = data[2:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(int poor, int low, int mid, int lim);
    logic [6:0] junk;
    settle_idle();
    junk = 7'($urandom_range(0, 127));
    write_reg(CFG_SNR_POOR, poor[9:0]);
    write_reg(CFG_SNR_LOW, low[9:0]);
    write_reg(CFG_SNR_MID, mid[9:0]);
    // upper data bits are ignored by the failure limit register
    write_reg(CFG_FAIL_LIM, {junk, lim[2:0]});
    settings_used++;
  endtask

  function automatic logic signed [9:0] pick_snr();
    int v;
    case ($urandom_range(0, 4))
      0: v = $urandom_range(0, 1023) - 512;
      1: v = int'($signed(cur_cfg.snr_poor)) + $urandom_range(0, 8) - 4;
      2: v = int'($signed(cur_cfg.snr_low)) + $urandom_range(0, 8) - 4;
      3: v = int'($signed(cur_cfg.snr_mid)) + $urandom_range(0, 8) - 4;
      default: v = $urandom_range(0, 1) ? 511 : -512;
    endcase
    if (v > 511) v = 511;
    if (v < -512) v = -512;
    return v[9:0];
  endfunction

  task automatic run_random_traffic(int n_items);
    logic [5:0] hot [4];
    logic [5:0] st;
    logic [3:0] maxr;
    op_t op;
    int k, run_len, i;
    for (i = 0; i < 4; i++) hot[i] = 6'($urandom_range(0, 63));
    k = 0;
    while (k < n_items) begin
      if ($urandom_range(0, 4) != 0) begin
        // outcome runs on a few busy stations to walk the history ring
        st      = hot[$urandom_range(0, 3)];
        run_len = $urandom_range(1, 8);
        op      = $urandom_range(0, 1) ? OP_FAILURE : OP_SUCCESS;
        maxr    = $urandom_range(0, 1) ? 4'd15 : 4'($urandom_range(0, 15));
        for (i = 0; i < run_len; i++) begin
          if ($urandom_range(0, 5) == 0) op = (op == OP_SUCCESS) ? OP_FAILURE : OP_SUCCESS;
          send_event(op, st, pick_snr(), maxr);
          k++;
        end
      end else begin
        op = $urandom_range(0, 1) ? OP_FAILURE : OP_SUCCESS;
        send_event(op, 6'($urandom_range(0, 63)), 10'($urandom_range(0, 1023)),
                   4'($urandom_range(0, 15)));
        k++;
      end
    end
  endtask

  task automatic test_default_bands();
    send_event(OP_SUCCESS, 6'd0, 10'sd511, 4'd15);
    send_event(OP_SUCCESS, 6'd0, 10'sd511, 4'd0);
    send_event(OP_FAILURE, 6'd63, -10'sd512, 4'd15);
    send_event(OP_FAILURE, 6'd63, -10'sd512, 4'd15);
    send_event(OP_SUCCESS, 6'd63, 10'sd70, 4'd15);
    send_event(OP_SUCCESS, 6'd63, 10'sd50, 4'd0);
    send_event(OP_SUCCESS, 6'd63, 10'sd120, 4'd15);
    send_event(OP_SUCCESS, 6'd5, -10'sd512, 4'd15);
    repeat (4) send_event(OP_FAILURE, 6'd5, 10'sd0, 4'd15);
    // failure count at the limit forces a step down
    send_event(OP_SUCCESS, 6'd5, 10'sd511, 4'd15);
    // rate left above a smaller maximum is not clamped on step down
    send_event(OP_SUCCESS, 6'd1, 10'sd511, 4'd15);
    send_event(OP_FAILURE, 6'd1, 10'sd0, 4'd15);
    send_event(OP_FAILURE, 6'd1, 10'sd0, 4'd15);
    send_event(OP_SUCCESS, 6'd1, 10'sd10, 4'd3);
  endtask

  task automatic test_threshold_extremes();
    // zero failure limit: every success steps down
    apply_settings(-512, -512, -512, 0);
    send_event(OP_SUCCESS, 6'd2, 10'sd0, 4'd15);
    send_event(OP_SUCCESS, 6'd2, -10'sd512, 4'd15);
    // poor and low bands at the minimum, mid band at the maximum, limit never reached
    apply_settings(-512, -512, 511, 7);
    send_event(OP_SUCCESS, 6'd3, 10'sd0, 4'd15);
    send_event(OP_SUCCESS, 6'd3, 10'sd511, 4'd15);
    repeat (3) send_event(OP_FAILURE, 6'd3, 10'sd511, 4'd15);
    send_event(OP_SUCCESS, 6'd3, 10'sd511, 4'd9);
  endtask

  task automatic test_random_settings();
    int a, b, c;
    apply_settings(SNR_POOR_RST, SNR_LOW_RST, SNR_MID_RST, FAIL_LIM_RST);
    run_random_traffic(165);
    apply_settings(-512, -512, -512, 0);
    run_random_traffic(165);
    apply_settings(511, 511, 511, 7);
    run_random_traffic(165);
    a = $urandom_range(0, 200) - 100;
    b = a + $urandom_range(0, 150);
    c = b + $urandom_range(0, 150);
    apply_settings(a, b, c, $urandom_range(1, 5));
    run_random_traffic(165);
    apply_settings($urandom_range(0, 1023) - 512, $urandom_range(0, 1023) - 512,
                   $urandom_range(0, 1023) - 512, $urandom_range(0, 7));
    run_random_traffic(165);
    apply_settings(20, 80, 140, $urandom_range(1, 3));
    run_random_traffic(165);
  endtask

  task automatic report_field(string field, int want, int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d actual %0d (result %0d)", field, want, got,
               results_checked);
  endtask

  // receiver stall pattern: free running, coin flip, or long stalls
  always @(posedge clk) begin
    ready_phase++;
    if (ready_phase >= 97) begin
      ready_phase = 0;
      ready_mode  = $urandom_range(0, 2);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_update.station = out_station_out;
      got_update.rate    = out_rate_index;
      got_update.fails   = out_recent_failures;
      if (expected_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: station %0d rate %0d failures %0d",
                   got_update.station, got_update.rate, got_update.fails);
      end else begin
        want_update = expected_updates.pop_front();
        if (got_update.station !== want_update.station)
          report_field("station_out", want_update.station, got_update.station);
        if (got_update.rate !== want_update.rate)
          report_field("rate_index", want_update.rate, got_update.rate);
        if (got_update.fails !== want_update.fails)
          report_field("recent_failures", want_update.fails, got_update.fails);
        results_checked++;
      end
    end
  end

  initial begin
    clear_station_table();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_default_bands();
    test_threshold_extremes();
    test_random_settings();
    settle_idle();
    $display("%0d events over %0d threshold settings, %0d words checked, %0d mismatches",
             events_sent, settings_used, results_checked, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ snr_history_rate_adapter_core.f @@
hdl/shra_pkg.sv
hdl/shra_front.sv
hdl/shra_queue.sv
hdl/shra_back.sv
hdl/snr_history_rate_adapter_core.sv
hdl/shra_chk.sv
tb/sv/tb_snr_history_rate_adapter_core.sv
